@@ rtl/extent_runlist_decoder_assert.svh @@
// Assertion macros shared by the run list decoder RTL.
`ifndef EXTENT_RUNLIST_DECODER_ASSERT_SVH
`define EXTENT_RUNLIST_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ERD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ERD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/erd_pkg.sv @@
package erd_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_INDEX_W-1:0] CFG_CLUSTER_SHIFT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_SIZE     = 1'b1;

    localparam logic [4:0]  CLUSTER_SHIFT_RESET = 5'd12;
    localparam logic [3:0]  MAX_FIELD_BYTES     = 4'd8;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_OFFSET = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN       = 3'd0,
        ST_END       = 3'd1,
        ST_BUF_END   = 3'd2,
        ST_SIZE      = 3'd3,
        ST_MALFORMED = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] list_byte;
        logic       start_of_list;
        logic       last_in_buffer;
    } in_item_t;

    typedef struct packed {
        logic [47:0] start_cluster;
        logic [47:0] run_clusters;
        logic        is_sparse;
        status_t     status;
        logic        list_done;
    } out_item_t;

    // Sign-extend a little-endian field of size bytes (1..7) to 64 bits.
    function automatic logic [63:0] erd_sext(input logic [63:0] value, input logic [3:0] size);
        logic [63:0] result;
        logic        sign;
        result = value;
        sign   = 1'b0;
        for (int k = 1; k < 8; k++) begin
            if (size == 4'(k)) begin
                sign = value[8*k-1];
            end
        end
        for (int k = 0; k < 8; k++) begin
            if (sign && (4'(k) >= size)) begin
                result[8*k +: 8] = 8'hFF;
            end
        end
        return result;
    endfunction

endpackage

@@ rtl/extent_runlist_decoder.sv @@
// Extent run list decoder.
// Input channel (s_valid/s_ready/s_data): one run list byte per request, with
// start_of_list marking the first byte of a list and last_in_buffer the final
// byte of the buffer. Result channel (m_valid/m_ready/m_data): one request per
// decoded run or list end, carrying start cluster, length, sparse mark, status
// and list_done on the final result of a list.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 cluster
// shift, 1 file size in bytes) in the same cycle; write only while idle.
// Throughput: one byte per cycle while the result channel is not stalled. A
// byte accepted into the input register has its result loaded into the result
// register (input register, then result register). All parsing for a byte is
// done between these two registers in one pass.
// Stall: while a result waits with m_ready low, the whole pipe holds and
// s_ready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous): parser returns to header phase, running
// cluster and byte position clear, cluster shift returns to 12, file size 0.
// After a list ends, bytes are dropped silently until start_of_list.
`include "extent_runlist_decoder_assert.svh"

module extent_runlist_decoder #(
    parameter int CLUSTER_BITS = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  erd_pkg::in_item_t                   s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output erd_pkg::out_item_t                  m_data,

    input  logic                                cfg_we,
    input  logic [erd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [erd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // Cluster numbers and lengths must stay below this bound.
    localparam logic [63:0] LIMIT = 64'(1) << CLUSTER_BITS;

    // Configuration registers.
    logic [4:0]             cluster_shift_reg;
    logic [47:0]            file_size_reg;

    // Pipe control: input register and result register.
    logic                   in_valid_reg;
    erd_pkg::in_item_t      in_reg;
    logic                   m_valid_reg;
    erd_pkg::out_item_t     m_data_reg;
    logic                   advance;
    logic                   proc;

    // Parser state.
    erd_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]             ls_reg, ls_next;
    logic [3:0]             os_reg, os_next;
    logic [3:0]             idx_reg, idx_next;
    logic [63:0]            lacc_reg, lacc_next;
    logic [63:0]            oacc_reg, oacc_next;
    logic [CLUSTER_BITS-1:0] running_reg, running_next;
    logic [63:0]            pos_reg, pos_next;

    // State as seen by this byte once start_of_list has cleared it.
    erd_pkg::phase_t        eff_phase;
    logic [3:0]             eff_ls, eff_os, eff_idx;
    logic [63:0]            eff_lacc, eff_oacc, eff_pos;
    logic [CLUSTER_BITS-1:0] eff_running;

    logic [7:0]             cur_byte;
    logic                   cur_last;
    logic [3:0]             idx_inc;
    logic [63:0]            lacc_upd, oacc_upd;

    // Per-byte decisions.
    logic                   hdr_stop;
    erd_pkg::status_t       stop_status;
    logic                   field_done;
    logic                   do_finish;
    logic [63:0]            fin_len, fin_off;
    logic [3:0]             fin_os;

    // Run finish datapath.
    logic                   fin_sparse;
    logic [63:0]            fin_soff;
    logic [63:0]            fin_sum;
    logic                   fin_bad;
    logic [127:0]           fin_shifted;
    logic [63:0]            fin_add;
    logic [64:0]            fin_pos_sum;
    logic [63:0]            fin_pos;

    erd_pkg::out_item_t     out_next;
    logic                   out_valid_next;

    // The whole pipe advances unless a result is stuck at the output.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;
    assign proc    = advance && in_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_shift_reg <= erd_pkg::CLUSTER_SHIFT_RESET;
            file_size_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                erd_pkg::CFG_CLUSTER_SHIFT: cluster_shift_reg <= cfg_wdata[4:0];
                erd_pkg::CFG_FILE_SIZE:     file_size_reg     <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    // Input register: capture the request, or go empty when nothing arrives.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg <= s_data;
        end
    end

    // start_of_list clears running cluster, position and parser first.
    always_comb begin
        cur_byte = in_reg.list_byte;
        cur_last = in_reg.last_in_buffer;
        if (in_reg.start_of_list) begin
            eff_phase   = erd_pkg::PH_HEADER;
            eff_ls      = '0;
            eff_os      = '0;
            eff_idx     = '0;
            eff_lacc    = '0;
            eff_oacc    = '0;
            eff_running = '0;
            eff_pos     = '0;
        end else begin
            eff_phase   = phase_reg;
            eff_ls      = ls_reg;
            eff_os      = os_reg;
            eff_idx     = idx_reg;
            eff_lacc    = lacc_reg;
            eff_oacc    = oacc_reg;
            eff_running = running_reg;
            eff_pos     = pos_reg;
        end
    end

    // Fold this byte into whichever field is being read, little-endian.
    assign idx_inc  = eff_idx + 4'd1;
    assign lacc_upd = eff_lacc | (64'(cur_byte) << {eff_idx[2:0], 3'b000});
    assign oacc_upd = eff_oacc | (64'(cur_byte) << {eff_idx[2:0], 3'b000});

    // Decide what this byte does: stop the list, finish a run, or just advance.
    always_comb begin
        hdr_stop    = 1'b0;
        stop_status = erd_pkg::ST_END;
        field_done  = 1'b0;
        do_finish   = 1'b0;
        fin_len     = eff_lacc;
        fin_off     = eff_oacc;
        fin_os      = eff_os;
        unique case (eff_phase)
            erd_pkg::PH_HEADER: begin
                if (cur_byte == 8'd0) begin
                    hdr_stop    = 1'b1;
                    stop_status = erd_pkg::ST_END;
                end else if (eff_pos >= 64'(file_size_reg)) begin
                    hdr_stop    = 1'b1;
                    stop_status = erd_pkg::ST_SIZE;
                end else if (cur_byte[3:0] == 4'd0) begin
                    hdr_stop    = 1'b1;
                    stop_status = erd_pkg::ST_END;
                end else if (cur_byte[3:0] > erd_pkg::MAX_FIELD_BYTES ||
                             cur_byte[7:4] > erd_pkg::MAX_FIELD_BYTES) begin
                    hdr_stop    = 1'b1;
                    stop_status = erd_pkg::ST_MALFORMED;
                end else begin
                    // A header on the last byte yields an empty, cut run.
                    do_finish = cur_last;
                    fin_len   = '0;
                    fin_off   = '0;
                    fin_os    = cur_byte[7:4];
                end
            end
            erd_pkg::PH_LENGTH: begin
                field_done = (idx_inc >= eff_ls);
                do_finish  = (field_done && eff_os == 4'd0) || cur_last;
                fin_len    = lacc_upd;
            end
            erd_pkg::PH_OFFSET: begin
                field_done = (idx_inc >= eff_os);
                do_finish  = field_done || cur_last;
                fin_off    = oacc_upd;
            end
            erd_pkg::PH_DONE: begin
                // Drop bytes until the next list starts.
            end
            default: ;
        endcase
    end

    // Finish a run: new start cluster, range checks and position advance.
    assign fin_sparse  = (fin_os == 4'd0);
    assign fin_soff    = erd_pkg::erd_sext(fin_off, fin_os);
    assign fin_sum     = 64'(eff_running) + fin_soff;
    assign fin_bad     = (fin_len >= LIMIT) ||
                         (!fin_sparse && (fin_sum[63] || fin_sum >= LIMIT));
    assign fin_shifted = {64'd0, fin_len} << cluster_shift_reg;
    assign fin_add     = (|fin_shifted[127:64]) ? '1 : fin_shifted[63:0];
    assign fin_pos_sum = {1'b0, eff_pos} + {1'b0, fin_add};
    assign fin_pos     = fin_pos_sum[64] ? '1 : fin_pos_sum[63:0];

    // Next parse phase.
    always_comb begin
        phase_next = eff_phase;
        if (hdr_stop) begin
            phase_next = erd_pkg::PH_DONE;
        end else if (do_finish) begin
            phase_next = (fin_bad || cur_last) ? erd_pkg::PH_DONE : erd_pkg::PH_HEADER;
        end else begin
            unique case (eff_phase)
                erd_pkg::PH_HEADER: phase_next = erd_pkg::PH_LENGTH;
                erd_pkg::PH_LENGTH: begin
                    phase_next = field_done ? erd_pkg::PH_OFFSET : erd_pkg::PH_LENGTH;
                end
                erd_pkg::PH_OFFSET: phase_next = erd_pkg::PH_OFFSET;
                erd_pkg::PH_DONE:   phase_next = erd_pkg::PH_DONE;
                default:            phase_next = erd_pkg::PH_DONE;
            endcase
        end
    end

    // Next datapath state and the result for this byte.
    always_comb begin
        ls_next      = eff_ls;
        os_next      = eff_os;
        idx_next     = eff_idx;
        lacc_next    = eff_lacc;
        oacc_next    = eff_oacc;
        running_next = eff_running;
        pos_next     = eff_pos;

        out_next               = '0;
        out_next.status        = stop_status;
        out_next.list_done     = 1'b1;
        out_valid_next         = hdr_stop || do_finish;

        unique case (eff_phase)
            erd_pkg::PH_HEADER: begin
                if (!hdr_stop) begin
                    ls_next   = cur_byte[3:0];
                    os_next   = cur_byte[7:4];
                    idx_next  = '0;
                    lacc_next = '0;
                    oacc_next = '0;
                end
            end
            erd_pkg::PH_LENGTH: begin
                lacc_next = lacc_upd;
                idx_next  = field_done ? 4'd0 : idx_inc;
            end
            erd_pkg::PH_OFFSET: begin
                oacc_next = oacc_upd;
                idx_next  = idx_inc;
            end
            erd_pkg::PH_DONE: ;
            default: ;
        endcase

        if (do_finish) begin
            if (fin_bad) begin
                out_next.status = erd_pkg::ST_MALFORMED;
            end else begin
                out_next.start_cluster = fin_sparse ? 48'd0 : fin_sum[47:0];
                out_next.run_clusters  = fin_len[47:0];
                out_next.is_sparse     = fin_sparse;
                out_next.status        = cur_last ? erd_pkg::ST_BUF_END : erd_pkg::ST_RUN;
                out_next.list_done     = cur_last;
                if (!fin_sparse) begin
                    running_next = fin_sum[CLUSTER_BITS-1:0];
                end
                pos_next  = fin_pos;
                idx_next  = '0;
                lacc_next = '0;
                oacc_next = '0;
            end
        end
    end

    // Parser state: advance only when a byte is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= erd_pkg::PH_HEADER;
            ls_reg      <= '0;
            os_reg      <= '0;
            idx_reg     <= '0;
            lacc_reg    <= '0;
            oacc_reg    <= '0;
            running_reg <= '0;
            pos_reg     <= '0;
        end else if (proc) begin
            phase_reg   <= phase_next;
            ls_reg      <= ls_next;
            os_reg      <= os_next;
            idx_reg     <= idx_next;
            lacc_reg    <= lacc_next;
            oacc_reg    <= oacc_next;
            running_reg <= running_next;
            pos_reg     <= pos_next;
        end
    end

    // Result register: load a new result or go empty once the old one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= in_valid_reg && out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_data_reg <= out_next;
        end
    end

    `ERD_ASSERT_NEXT(a_done_drops_bytes,
        proc && !in_reg.start_of_list && phase_reg == erd_pkg::PH_DONE,
        !m_valid_reg,
        "byte after end of list produced a result")

    `ERD_ASSERT_NEXT(a_final_result_ends_list,
        proc && out_valid_next && out_next.list_done,
        phase_reg == erd_pkg::PH_DONE,
        "parser not parked after final result")

    `ERD_ASSERT_IMP(a_field_index_in_range,
        (phase_reg == erd_pkg::PH_LENGTH && idx_reg >= ls_reg) ||
        (phase_reg == erd_pkg::PH_OFFSET && idx_reg >= os_reg),
        1'b0,
        "field byte index past field size")

    `ERD_ASSERT_IMP(a_non_run_fields_zero,
        m_valid_reg && m_data_reg.status != erd_pkg::ST_RUN &&
        m_data_reg.status != erd_pkg::ST_BUF_END,
        m_data_reg.start_cluster == 48'd0 && m_data_reg.run_clusters == 48'd0 &&
        !m_data_reg.is_sparse && m_data_reg.list_done,
        "list end result carries run fields")

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    localparam int          RUN_BITS  = 48;
    localparam logic [63:0] RUN_LIMIT = 64'd1 << RUN_BITS;
    localparam logic [63:0] ALL_ONES  = '1;
    localparam logic [47:0] FSIZE_MAX = '1;

    // Every input of the block holds a known value from time zero.
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    erd_pkg::in_item_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    erd_pkg::out_item_t              m_data;
    logic                            cfg_we    = 1'b0;
    logic [erd_pkg::CFG_INDEX_W-1:0] cfg_index = erd_pkg::CFG_CLUSTER_SHIFT;
    logic [erd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // Mirror of the decoder: parser, running cluster, byte position and registers.
    erd_pkg::phase_t prs_phase  = erd_pkg::PH_HEADER;
    logic [3:0]      prs_len_sz = '0;
    logic [3:0]      prs_off_sz = '0;
    logic [3:0]      prs_idx    = '0;
    logic [63:0]     prs_len    = '0;
    logic [63:0]     prs_off    = '0;
    logic [63:0]     prs_lcn    = '0;
    logic [63:0]     prs_pos    = '0;
    logic [4:0]      reg_shift  = erd_pkg::CLUSTER_SHIFT_RESET;
    logic [47:0]     reg_fsize  = '0;

    erd_pkg::in_item_t  byte_backlog[$];   // bytes waiting to be offered to the decoder
    erd_pkg::out_item_t due_results[$];    // decoded runs and list ends still owed
    erd_pkg::out_item_t next_result;
    erd_pkg::out_item_t want;
    int        mismatches = 0;
    int        in_hold    = 0;
    int        out_hold   = 0;
    int        stall;
    bit        in_steady  = 1'b0;
    bit        out_steady = 1'b0;

    extent_runlist_decoder #(
        .CLUSTER_BITS(RUN_BITS)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Build one result; a final result parks the parser until the next list.
    function automatic erd_pkg::out_item_t make_result(input logic [63:0] start,
                                                       input logic [63:0] len,
                                                       input logic sparse,
                                                       input erd_pkg::status_t st,
                                                       input logic done);
        erd_pkg::out_item_t res;
        res.start_cluster = start[47:0];
        res.run_clusters  = len[47:0];
        res.is_sparse     = sparse;
        res.status        = st;
        res.list_done     = done;
        if (done) begin
            prs_phase = erd_pkg::PH_DONE;
        end
        return res;
    endfunction

    // Close the run held in the parser: check ranges, move the running cluster
    // and the byte position, and return the run (or a malformed list end).
    function automatic erd_pkg::out_item_t close_run(input logic cut);
        logic [63:0] off;
        logic [63:0] start;
        logic [63:0] add;
        logic [63:0] len;
        logic        sparse;
        int          nbits;
        len    = prs_len;
        sparse = (prs_off_sz == 4'd0);
        start  = '0;
        if (len >= RUN_LIMIT) begin
            return make_result('0, '0, 1'b0, erd_pkg::ST_MALFORMED, 1'b1);
        end
        if (!sparse) begin
            off = prs_off;
            // Sign-extend from the top bit of the declared field size.
            if (prs_off_sz < erd_pkg::MAX_FIELD_BYTES) begin
                nbits = int'(prs_off_sz) * 8;
                if (off[nbits-1]) begin
                    off = off | ~((64'd1 << nbits) - 64'd1);
                end
            end
            start = prs_lcn + off;
            if (start[63] || start >= RUN_LIMIT) begin
                return make_result('0, '0, 1'b0, erd_pkg::ST_MALFORMED, 1'b1);
            end
            prs_lcn = start;
        end
        // Advance the byte position, saturating on overflow.
        add     = (len <= (ALL_ONES >> reg_shift)) ? (len << reg_shift) : ALL_ONES;
        prs_pos = (prs_pos > ~add) ? ALL_ONES : prs_pos + add;
        prs_idx   = '0;
        prs_len   = '0;
        prs_off   = '0;
        prs_phase = erd_pkg::PH_HEADER;
        return make_result(start, len, sparse,
                           cut ? erd_pkg::ST_BUF_END : erd_pkg::ST_RUN, cut);
    endfunction

    // Feed one accepted byte through the parser; returns 1 when it yields a result.
    function automatic bit decode_byte(input erd_pkg::in_item_t it,
                                       output erd_pkg::out_item_t res);
        logic [7:0] b;
        logic       last;
        b    = it.list_byte;
        last = it.last_in_buffer;
        res  = '0;
        if (it.start_of_list) begin
            prs_lcn    = '0;
            prs_pos    = '0;
            prs_phase  = erd_pkg::PH_HEADER;
            prs_len_sz = '0;
            prs_off_sz = '0;
            prs_idx    = '0;
            prs_len    = '0;
            prs_off    = '0;
        end
        case (prs_phase)
            erd_pkg::PH_HEADER: begin
                if (b == 8'h00) begin
                    res = make_result('0, '0, 1'b0, erd_pkg::ST_END, 1'b1);
                    return 1'b1;
                end
                if (prs_pos >= 64'(reg_fsize)) begin
                    res = make_result('0, '0, 1'b0, erd_pkg::ST_SIZE, 1'b1);
                    return 1'b1;
                end
                prs_len_sz = b[3:0];
                prs_off_sz = b[7:4];
                if (prs_len_sz == 4'd0) begin
                    res = make_result('0, '0, 1'b0, erd_pkg::ST_END, 1'b1);
                    return 1'b1;
                end
                if (prs_len_sz > erd_pkg::MAX_FIELD_BYTES ||
                    prs_off_sz > erd_pkg::MAX_FIELD_BYTES) begin
                    res = make_result('0, '0, 1'b0, erd_pkg::ST_MALFORMED, 1'b1);
                    return 1'b1;
                end
                prs_idx   = '0;
                prs_len   = '0;
                prs_off   = '0;
                prs_phase = erd_pkg::PH_LENGTH;
                if (last) begin
                    res = close_run(1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            erd_pkg::PH_LENGTH: begin
                prs_len = prs_len | (64'(b) << (int'(prs_idx[2:0]) * 8));
                prs_idx = prs_idx + 4'd1;
                if (prs_idx >= prs_len_sz) begin
                    prs_idx = '0;
                    if (prs_off_sz == 4'd0) begin
                        res = close_run(last);
                        return 1'b1;
                    end
                    prs_phase = erd_pkg::PH_OFFSET;
                end
                if (last) begin
                    res = close_run(1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            erd_pkg::PH_OFFSET: begin
                prs_off = prs_off | (64'(b) << (int'(prs_idx[2:0]) * 8));
                prs_idx = prs_idx + 4'd1;
                if (prs_idx >= prs_off_sz || last) begin
                    res = close_run(last);
                    return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic erd_pkg::in_item_t mk(input logic [7:0] b, input logic sol,
                                             input logic last);
        erd_pkg::in_item_t it;
        it.list_byte      = b;
        it.start_of_list  = sol;
        it.last_in_buffer = last;
        return it;
    endfunction

    task automatic push(input logic [7:0] b, input logic sol, input logic last);
        byte_backlog.push_back(mk(b, sol, last));
    endtask

    // Queue one run list: mostly well-formed runs with random sizes and offsets
    // that keep the running cluster in range, closed by one of the list ends;
    // the rest are abandoned lists and raw byte noise.
    task automatic queue_list(inout int queued);
        erd_pkg::in_item_t lst[$];
        erd_pkg::in_item_t it;
        int          nruns;
        int          ending;
        int          ls;
        int          os;
        int          cut;
        logic [63:0] gen_lcn;
        logic [63:0] tgt;
        logic [63:0] delta;
        logic [7:0]  b;
        gen_lcn = '0;
        nruns   = $urandom_range(0, 5);
        ending  = $urandom_range(0, 9);
        for (int r = 0; r < nruns; r++) begin
            ls    = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            os    = 0;
            delta = '0;
            if ($urandom_range(0, 4) != 0) begin
                if ($urandom_range(0, 11) == 0) begin
                    // Arbitrary offset bytes: may land negative or out of range.
                    os    = $urandom_range(1, 8);
                    delta = {$urandom, $urandom};
                end else begin
                    tgt   = {$urandom, $urandom};
                    tgt   = (tgt & 64'(FSIZE_MAX)) >> $urandom_range(0, 47);
                    delta = tgt - gen_lcn;
                    // Pick the narrowest field that holds the signed delta.
                    os = 8;
                    for (int n = 7; n >= 1; n--) begin
                        if ((delta >> (8*n - 1)) == '0 ||
                            (delta >> (8*n - 1)) == (ALL_ONES >> (8*n - 1))) begin
                            os = n;
                        end
                    end
                    if (os < 8 && $urandom_range(0, 5) == 0) begin
                        os++;
                    end
                    gen_lcn = tgt;
                end
            end
            lst.push_back(mk({4'(os), 4'(ls)}, 1'b0, 1'b0));
            for (int i = 0; i < ls; i++) begin
                b = 8'($urandom);
                // Keep most long lengths below the cluster limit.
                if (i >= 6 && $urandom_range(0, 3) != 0) begin
                    b = '0;
                end
                lst.push_back(mk(b, 1'b0, 1'b0));
            end
            for (int i = 0; i < os; i++) begin
                lst.push_back(mk(delta[8*i +: 8], 1'b0, 1'b0));
            end
        end
        case (ending)
            0, 1: begin
                lst.push_back(mk(8'h00, 1'b0, 1'b0));
            end
            2: begin
                lst.push_back(mk({4'($urandom_range(0, 15)), 4'h0}, 1'b0, 1'b0));
            end
            3, 4: begin
                // Buffer ends on the final byte of the last run.
                if (lst.size() == 0) begin
                    lst.push_back(mk(8'h11, 1'b0, 1'b0));
                end
                it = lst.pop_back();
                it.last_in_buffer = 1'b1;
                lst.push_back(it);
            end
            5: begin
                // Buffer ends somewhere inside a run, header byte included.
                if (lst.size() == 0) begin
                    lst.push_back(mk(8'h31, 1'b0, 1'b0));
                end
                cut = $urandom_range(1, lst.size());
                while (lst.size() > cut) begin
                    void'(lst.pop_back());
                end
                it = lst.pop_back();
                it.last_in_buffer = 1'b1;
                lst.push_back(it);
            end
            6: begin
                // Oversized length or offset field.
                if ($urandom_range(0, 1) == 0) begin
                    b = {4'($urandom_range(0, 8)), 4'($urandom_range(9, 15))};
                end else begin
                    b = {4'($urandom_range(9, 15)), 4'($urandom_range(1, 15))};
                end
                lst.push_back(mk(b, 1'b0, 1'b0));
            end
            7: begin
                // Abandon the list mid-way; the next start_of_list restarts it.
                if (lst.size() > 1) begin
                    cut = $urandom_range(1, lst.size());
                    while (lst.size() > cut) begin
                        void'(lst.pop_back());
                    end
                end
            end
            default: begin
                lst.delete();
                repeat ($urandom_range(1, 12)) begin
                    lst.push_back(mk(8'($urandom), $urandom_range(0, 7) == 0,
                                     $urandom_range(0, 7) == 0));
                end
            end
        endcase
        if (lst.size() != 0) begin
            it = lst.pop_front();
            it.start_of_list = 1'b1;
            lst.push_front(it);
        end
        queued += lst.size();
        foreach (lst[i]) begin
            byte_backlog.push_back(lst[i]);
        end
        // Trailing bytes: dropped by the block after a list end, parsed after an abandoned list or noise.
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                push(8'($urandom), 1'b0, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // Write one register; the mirror follows since nothing is in flight.
    task automatic set_register(input logic [erd_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [47:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == erd_pkg::CFG_CLUSTER_SHIFT) begin
            reg_shift = value[4:0];
        end else begin
            reg_fsize = value;
        end
    endtask

    // Wait until every byte is taken and every owed result is in, then let the
    // two-stage pipe flush bytes that produce nothing.
    task automatic settle();
        while (byte_backlog.size() != 0 || s_valid || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // Byte driver: offer the next queued byte, hold it until taken, then idle
    // for a random number of cycles (none during steady stretches).
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            in_hold <= 0;
        end else if (!s_valid || s_ready) begin
            // Predict at the accepting edge so the expectation is queued well
            // before the result can come out.
            if (s_valid) begin
                if (decode_byte(s_data, next_result)) begin
                    due_results.push_back(next_result);
                end
            end
            if (in_hold != 0) begin
                s_valid <= 1'b0;
                in_hold <= in_hold - 1;
            end else if (byte_backlog.size() != 0) begin
                s_data  <= byte_backlog.pop_front();
                s_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    in_steady = !in_steady;
                end
                in_hold <= in_steady ? 0 : $urandom_range(0, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor: compare each request against the oldest owed result,
    // then drop ready for a random stretch before the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            out_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: start %h len %h sparse %b status %0d",
                                 m_data.start_cluster, m_data.run_clusters, m_data.is_sparse,
                                 m_data.status);
                        $display("    done %b", m_data.list_done);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (want.start_cluster !== m_data.start_cluster ||
                        want.run_clusters !== m_data.run_clusters ||
                        want.is_sparse !== m_data.is_sparse ||
                        want.status !== m_data.status ||
                        want.list_done !== m_data.list_done) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch (expected/actual): start %h/%h len %h/%h",
                                     want.start_cluster, m_data.start_cluster,
                                     want.run_clusters, m_data.run_clusters);
                            $display("    sparse %b/%b status %0d/%0d done %b/%b",
                                     want.is_sparse, m_data.is_sparse, want.status,
                                     m_data.status, want.list_done, m_data.list_done);
                        end
                    end
                end
                if ($urandom_range(0, 29) == 0) begin
                    out_steady = !out_steady;
                end
                stall = out_steady ? 0 : $urandom_range(0, 9);
                out_hold <= stall;
                m_ready  <= (stall == 0);
            end else if (out_hold > 1) begin
                out_hold <= out_hold - 1;
            end else begin
                out_hold <= 0;
                m_ready  <= 1'b1;
            end
        end
    end

    // Stimulus sequence and end of test.
    initial begin
        int          queued;
        int          budget;
        logic [4:0]  shift_plan [6];
        logic [47:0] fsize_plan [6];
        shift_plan = '{5'd9, 5'd21, 5'd12, 5'd16, 5'd10, 5'd19};
        fsize_plan[0] = FSIZE_MAX;
        fsize_plan[1] = FSIZE_MAX;
        fsize_plan[2] = 48'({$urandom, $urandom});
        fsize_plan[3] = 48'd1 << $urandom_range(24, 36);
        fsize_plan[4] = 48'($urandom_range(1 << 14, 1 << 22));
        fsize_plan[5] = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset registers: file size 0, so the first header already hits the size limit.
        push(8'h11, 1'b1, 1'b0);
        settle();

        set_register(erd_pkg::CFG_CLUSTER_SHIFT, 48'd21);
        set_register(erd_pkg::CFG_FILE_SIZE, FSIZE_MAX);
        // Zero header ends the list; the byte after it is dropped.
        push(8'h00, 1'b1, 1'b0);
        push(8'h11, 1'b0, 1'b0);
        // Zero length size ends the list.
        push(8'h10, 1'b1, 1'b0);
        // Oversized length field, then oversized offset field.
        push(8'h19, 1'b1, 1'b0);
        push(8'h91, 1'b1, 1'b0);
        // Sparse run, then an offset that drives the start cluster negative.
        push(8'h01, 1'b1, 1'b0);
        push(8'hFF, 1'b0, 1'b0);
        push(8'h11, 1'b0, 1'b0);
        push(8'h05, 1'b0, 1'b0);
        push(8'h80, 1'b0, 1'b0);
        // Largest legal length saturates the position; the next header stops on size.
        push(8'h06, 1'b1, 1'b0);
        repeat (6) push(8'hFF, 1'b0, 1'b0);
        push(8'h01, 1'b0, 1'b0);
        // Buffer ends on a bare header, then on the last byte of a full run.
        push(8'h21, 1'b1, 1'b1);
        push(8'h11, 1'b1, 1'b0);
        push(8'h03, 1'b0, 1'b0);
        push(8'h7F, 1'b0, 1'b1);
        settle();

        // Random lists under several register settings, extremes included.
        for (int p = 0; p < 6; p++) begin
            set_register(erd_pkg::CFG_CLUSTER_SHIFT, 48'(shift_plan[p]));
            set_register(erd_pkg::CFG_FILE_SIZE, fsize_plan[p]);
            budget = (p == 5) ? 40 : 165;
            queued = 0;
            while (queued < budget) begin
                queue_list(queued);
            end
            settle();
        end

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/erd_pkg.sv
rtl/extent_runlist_decoder.sv
verif/tb_top.sv
